// ===== rtl/hhtd_pkg.sv =====
// Shared constants and control/status types for the heap-tree Huffman decoder.
`default_nettype none

package hhtd_pkg;

	localparam int TREE_ENTRIES = 1024;
	localparam int IDX_W        = $clog2(TREE_ENTRIES);
	// two spare bits: 2n+2 of the last entry reaches twice the table size
	localparam int CHILD_W      = IDX_W + 2;
	localparam int TOTAL_W      = 31;
	localparam int SYM_W        = 8;
	localparam int BYTE_W       = 8;
	localparam int BITCNT_W     = $clog2(BYTE_W);
	localparam int LOAD_IDX_W   = 10;

	localparam logic FUNC_LOAD = 1'b0;
	localparam logic FUNC_DATA = 1'b1;

	// commands from the controller to the datapath
	typedef struct packed {
		logic clr_step;
		logic load_wr;
		logic start;
		logic step;
		logic flush_push;
	} hhtd_cmd_t;

	// status from the datapath to the controller
	typedef struct packed {
		logic clr_last;
		logic can_start;
		logic more;
		logic hit;
		logic pend_valid;
		logic out_free;
	} hhtd_sts_t;

endpackage

`default_nettype wire

// ===== rtl/hhtd_if.sv =====
// Valid/ready channel interfaces for input items and result words.
`default_nettype none

interface hhtd_item_if;
	logic                              valid;
	logic                              ready;
	logic                              func;
	logic [hhtd_pkg::LOAD_IDX_W-1:0]   entry_index;
	logic [hhtd_pkg::SYM_W-1:0]        entry_symbol;
	logic [hhtd_pkg::BYTE_W-1:0]       data_byte;

	modport source (output valid, func, entry_index, entry_symbol, data_byte, input ready);
	modport sink   (input valid, func, entry_index, entry_symbol, data_byte, output ready);
endinterface

interface hhtd_result_if;
	logic                       valid;
	logic                       ready;
	logic [hhtd_pkg::SYM_W-1:0] symbol;
	logic                       error;
	logic                       last;

	modport source (output valid, symbol, error, last, input ready);
	modport sink   (input valid, symbol, error, last, output ready);
endinterface

`default_nettype wire

// ===== rtl/hhtd_ctrl.sv =====
// Controller: clearing pass, item intake and the bit-walk sequence.
`default_nettype none

module hhtd_ctrl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	input  wire logic                 func,
	output logic                      in_ready,
	input  wire hhtd_pkg::hhtd_sts_t  sts,
	output hhtd_pkg::hhtd_cmd_t       cmd
);

	localparam logic [1:0] ST_CLEAR = 2'd0;
	localparam logic [1:0] ST_IDLE  = 2'd1;
	localparam logic [1:0] ST_WALK  = 2'd2;
	localparam logic [1:0] ST_FLUSH = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       accept;
	logic       stall;

	assign accept = in_valid && in_ready;
	// a new result cannot displace the pending one while the output register is full
	assign stall  = sts.hit && sts.pend_valid && !sts.out_free;

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		cmd      = '0;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (accept) begin
					if (func == hhtd_pkg::FUNC_LOAD) begin
						cmd.load_wr = 1'b1;
					end else if (sts.can_start) begin
						cmd.start = 1'b1;
						state_d   = ST_WALK;
					end
				end
			end
			ST_WALK: begin
				cmd.step = !stall;
				if (!stall && !sts.more) begin
					state_d = ST_FLUSH;
				end
			end
			ST_FLUSH: begin
				if (!sts.pend_valid) begin
					state_d = ST_IDLE;
				end else if (sts.out_free) begin
					cmd.flush_push = 1'b1;
					state_d        = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

`ifndef NO_ASSERTIONS
	a_no_intake_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |-> !in_ready)
		else $error("item taken during clearing pass");
	a_walk_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start |=> (state_q == ST_WALK))
		else $error("start did not enter walk");
	a_step_only_walking: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |-> $past(cmd.start) || $past(cmd.step) || $past(stall))
		else $error("step issued without a read in flight");
`endif

endmodule

`default_nettype wire

// ===== rtl/hhtd_dpath.sv =====
// Datapath: tree memory, walk registers, pending result and output register.
`default_nettype none

module hhtd_dpath (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire hhtd_pkg::hhtd_cmd_t                  cmd,
	output hhtd_pkg::hhtd_sts_t                       sts,
	input  wire logic [hhtd_pkg::LOAD_IDX_W-1:0]      entry_index,
	input  wire logic [hhtd_pkg::SYM_W-1:0]           entry_symbol,
	input  wire logic [hhtd_pkg::BYTE_W-1:0]          data_byte,
	input  wire logic                                 cfg_we,
	input  wire logic [hhtd_pkg::TOTAL_W-1:0]         cfg_data,
	output logic                                      out_valid,
	input  wire logic                                 out_ready,
	output logic [hhtd_pkg::SYM_W-1:0]                out_symbol,
	output logic                                      out_error,
	output logic                                      out_last
);

	localparam logic [hhtd_pkg::CHILD_W-1:0] CHILD_LIMIT =
		hhtd_pkg::CHILD_W'(hhtd_pkg::TREE_ENTRIES);
	localparam logic [hhtd_pkg::IDX_W-1:0] CLR_END =
		hhtd_pkg::IDX_W'(hhtd_pkg::TREE_ENTRIES - 1);
	localparam logic [hhtd_pkg::BITCNT_W-1:0] BIT_LAST =
		hhtd_pkg::BITCNT_W'(hhtd_pkg::BYTE_W - 1);

	logic [hhtd_pkg::SYM_W-1:0]    mem [hhtd_pkg::TREE_ENTRIES];
	logic [hhtd_pkg::SYM_W-1:0]    rd_q;
	logic [hhtd_pkg::IDX_W-1:0]    clr_cnt_q;
	logic [hhtd_pkg::TOTAL_W-1:0]  total_q;
	logic [hhtd_pkg::TOTAL_W-1:0]  bits_q;
	logic [hhtd_pkg::IDX_W-1:0]    node_q;
	logic [hhtd_pkg::CHILD_W-1:0]  child_q;
	logic [hhtd_pkg::BYTE_W-1:0]   byte_q;
	logic [hhtd_pkg::BITCNT_W-1:0] bit_cnt_q;
	logic                          pend_valid_q;
	logic [hhtd_pkg::SYM_W-1:0]    pend_sym_q;
	logic                          pend_err_q;
	logic                          out_valid_q;
	logic [hhtd_pkg::SYM_W-1:0]    out_sym_q;
	logic                          out_err_q;
	logic                          out_last_q;

	logic                          child_err;
	logic                          hit;
	logic                          load_ok;
	logic [hhtd_pkg::IDX_W-1:0]    node_sel;
	logic                          bit_sel;
	logic [hhtd_pkg::CHILD_W-1:0]  next_child;
	logic                          mem_we;
	logic [hhtd_pkg::IDX_W-1:0]    mem_waddr;
	logic [hhtd_pkg::SYM_W-1:0]    mem_wdata;
	logic                          push_pend;
	logic                          out_free;

	assign child_err = child_q >= CHILD_LIMIT;
	assign hit       = child_err || (rd_q != '0);
	assign load_ok   = 32'(entry_index) < 32'(hhtd_pkg::TREE_ENTRIES);
	assign out_free  = !out_valid_q || out_ready;
	// an earlier result leaves as not-last once a newer one turns up in the same byte
	assign push_pend = cmd.step && hit && pend_valid_q;

	// after a leaf or an error the walk restarts from the root
	assign node_sel   = cmd.start ? node_q : (hit ? '0 : child_q[hhtd_pkg::IDX_W-1:0]);
	assign bit_sel    = cmd.start ? data_byte[hhtd_pkg::BYTE_W-1] : byte_q[hhtd_pkg::BYTE_W-2];
	assign next_child = hhtd_pkg::CHILD_W'({node_sel, 1'b0}) + hhtd_pkg::CHILD_W'(1) +
		hhtd_pkg::CHILD_W'(bit_sel);

	assign mem_we    = cmd.clr_step || (cmd.load_wr && load_ok);
	assign mem_waddr = cmd.clr_step ? clr_cnt_q : hhtd_pkg::IDX_W'(entry_index);
	assign mem_wdata = cmd.clr_step ? '0 : entry_symbol;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (cmd.start || cmd.step) begin
			rd_q <= mem[next_child[hhtd_pkg::IDX_W-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q    <= '0;
			total_q      <= '0;
			bits_q       <= '0;
			node_q       <= '0;
			bit_cnt_q    <= '0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cmd.clr_step) begin
				clr_cnt_q <= clr_cnt_q + hhtd_pkg::IDX_W'(1);
			end
			if (cfg_we) begin
				total_q <= cfg_data;
				bits_q  <= '0;
				node_q  <= '0;
			end else if (cmd.step) begin
				bits_q <= bits_q + hhtd_pkg::TOTAL_W'(1);
				node_q <= node_sel;
			end
			if (cmd.start) begin
				bit_cnt_q <= '0;
			end else if (cmd.step) begin
				bit_cnt_q <= bit_cnt_q + hhtd_pkg::BITCNT_W'(1);
			end
			if (cmd.step && hit) begin
				pend_valid_q <= 1'b1;
			end else if (cmd.flush_push) begin
				pend_valid_q <= 1'b0;
			end
			if (push_pend || cmd.flush_push) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start || cmd.step) begin
			child_q <= next_child;
		end
		if (cmd.start) begin
			byte_q <= data_byte;
		end else if (cmd.step) begin
			byte_q <= byte_q << 1;
		end
		if (cmd.step && hit) begin
			pend_sym_q <= child_err ? '0 : rd_q;
			pend_err_q <= child_err;
		end
		if (push_pend || cmd.flush_push) begin
			out_sym_q  <= pend_sym_q;
			out_err_q  <= pend_err_q;
			out_last_q <= cmd.flush_push;
		end
	end

	always_comb begin
		sts            = '0;
		sts.clr_last   = clr_cnt_q == CLR_END;
		sts.can_start  = bits_q < total_q;
		sts.more       = (bit_cnt_q != BIT_LAST) && ((bits_q + hhtd_pkg::TOTAL_W'(1)) < total_q);
		sts.hit        = hit;
		sts.pend_valid = pend_valid_q;
		sts.out_free   = out_free;
	end

	assign out_valid  = out_valid_q;
	assign out_symbol = out_sym_q;
	assign out_error  = out_err_q;
	assign out_last   = out_last_q;

`ifndef NO_ASSERTIONS
	a_push_into_free: assert property (@(posedge clk) disable iff (!arst_n)
		(push_pend || cmd.flush_push) |-> out_free)
		else $error("result word overwrote an untaken word");
	a_error_symbol_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_err_q) |-> (out_sym_q == '0))
		else $error("error word carries a symbol");
	a_not_last_has_successor: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_last_q) |-> pend_valid_q)
		else $error("non-last word without a following result");
`endif

endmodule

`default_nettype wire

// ===== rtl/huffman_heap_tree_decoder.sv =====
// Top level of the heap-tree Huffman decoder.
// After reset the tree memory is cleared one entry a cycle, all TREE_ENTRIES (1024)
// entries; no item is taken meanwhile, though total_bits may be written. A load word is
// written to the tree memory as it is taken. A data byte is taken, then decoded one bit
// per cycle (up to 8 bits) while the result port does not stall, and then the byte is
// closed; no new item is taken until it is closed. The bit rate is set by the tree walk:
// each bit is one read of the tree memory, and the next address depends on that read.
// Results of a byte come out in order, the final one marked by last.
`default_nettype none

module huffman_heap_tree_decoder (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	hhtd_item_if.sink                          items,
	hhtd_result_if.source                      results,
	input  wire logic                          cfg_we,
	input  wire logic [hhtd_pkg::TOTAL_W-1:0]  cfg_data
);

	hhtd_pkg::hhtd_cmd_t cmd;
	hhtd_pkg::hhtd_sts_t sts;

	hhtd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (items.valid),
		.func     (items.func),
		.in_ready (items.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	hhtd_dpath u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.entry_index  (items.entry_index),
		.entry_symbol (items.entry_symbol),
		.data_byte    (items.data_byte),
		.cfg_we       (cfg_we),
		.cfg_data     (cfg_data),
		.out_valid    (results.valid),
		.out_ready    (results.ready),
		.out_symbol   (results.symbol),
		.out_error    (results.error),
		.out_last     (results.last)
	);

endmodule

`default_nettype wire
